// ----- src/bmd_pkg.sv -----
package bmd_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [7:0] StatusBit   = 8'h80;
  localparam logic [7:0] SysNibble   = 8'hF0;
  localparam logic [7:0] SongPos     = 8'hF2;
  localparam logic [7:0] RealtimeMin = 8'hF8;
  localparam logic [7:0] ProgChange  = 8'hC0;
  localparam logic [7:0] ChanPress   = 8'hD0;
  localparam logic [7:0] PitchBend   = 8'hE0;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_STAMP  = 5'b00010,
    PH_MSG    = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_DATA   = 5'b10000
  } bmd_phase_e;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       clear_counts;
  } bmd_in_t;

  typedef struct packed {
    logic [1:0]  out_count;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [31:0] timestamp_drops;
    logic [31:0] invalid_drops;
    logic [31:0] truncated_drops;
    logic [31:0] bytes_received;
  } bmd_out_t;

  // MIDI bytes produced by one packet byte.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } bmd_msg_t;

  // Counter events caused by one packet byte.
  typedef struct packed {
    logic clear;
    logic stamp;
    logic invalid;
    logic trunc;
  } bmd_cnt_ev_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_len(input logic [7:0] st);
    logic [7:0] hi;
    hi = st & SysNibble;
    if (hi == ProgChange || hi == ChanPress) begin
      return 2'd1;
    end else if (st[7] && hi != SysNibble) begin
      return 2'd2;
    end else if (st == SongPos) begin
      return 2'd2;
    end
    return 2'd0;
  endfunction

endpackage

// ----- src/bmd_decode.sv -----
module bmd_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  bmd_pkg::bmd_in_t     item_i,
  output bmd_pkg::bmd_msg_t    msg_o,
  output bmd_pkg::bmd_cnt_ev_t ev_o
);
  import bmd_pkg::*;

  bmd_phase_e phase_q, phase_d;
  logic [7:0] run_q, run_d;
  logic [7:0] held_st_q, held_st_d;
  logic [6:0] held_dat_q, held_dat_d;
  logic [1:0] need_q, need_d;

  logic [7:0] b;
  logic       last;
  logic [1:0] need_b;
  logic [1:0] need_run;
  logic [1:0] total;

  assign b        = item_i.packet_byte;
  assign last     = item_i.packet_end;
  assign need_b   = data_len(b);
  assign need_run = data_len(run_q);
  assign total    = data_len(held_st_q);

  always_comb begin
    phase_d    = phase_q;
    run_d      = run_q;
    held_st_d  = held_st_q;
    held_dat_d = held_dat_q;
    need_d     = need_q;
    msg_o      = '0;
    ev_o       = '0;
    ev_o.clear = item_i.clear_counts;

    case (phase_q)
      PH_STAMP: begin
        if (b[7]) begin
          phase_d = PH_MSG;
        end else begin
          ev_o.stamp = 1'b1;
        end
      end
      PH_MSG: begin
        if (b >= RealtimeMin) begin
          msg_o.count = 2'd1;
          msg_o.byte0 = b;
          phase_d     = PH_STAMP;
        end else if (b[7]) begin
          run_d = (b < SysNibble) ? b : 8'h00;
          if (need_b == 2'd0) begin
            ev_o.stamp = 1'b1;
            phase_d    = PH_SKIP;
          end else if (last) begin
            ev_o.trunc = 1'b1;
          end else begin
            held_st_d  = b;
            held_dat_d = '0;
            need_d     = need_b;
            phase_d    = PH_DATA;
          end
        end else if (run_q == 8'h00) begin
          phase_d = PH_STAMP;
        end else if (need_run == 2'd1) begin
          msg_o.count = 2'd2;
          msg_o.byte0 = run_q;
          msg_o.byte1 = b;
          phase_d     = PH_STAMP;
        end else if (last) begin
          ev_o.trunc = 1'b1;
        end else begin
          held_st_d  = run_q;
          held_dat_d = b[6:0];
          need_d     = 2'd1;
          phase_d    = PH_DATA;
        end
      end
      PH_SKIP: begin
        phase_d = PH_STAMP;
      end
      PH_DATA: begin
        if (total == 2'd2 && need_q == 2'd1) begin
          if (b[7]) begin
            // The bad byte is taken as the timestamp of the next message.
            ev_o.invalid = 1'b1;
            phase_d      = PH_MSG;
          end else begin
            msg_o.count = 2'd3;
            msg_o.byte0 = held_st_q;
            msg_o.byte1 = {1'b0, held_dat_q};
            msg_o.byte2 = b;
            phase_d     = PH_STAMP;
          end
        end else if (total == 2'd2 && last) begin
          ev_o.trunc = 1'b1;
        end else if (b[7]) begin
          ev_o.invalid = 1'b1;
          phase_d      = PH_STAMP;
        end else if (total == 2'd2) begin
          held_dat_d = b[6:0];
          need_d     = 2'd1;
        end else begin
          msg_o.count = 2'd2;
          msg_o.byte0 = held_st_q;
          msg_o.byte1 = b;
          phase_d     = PH_STAMP;
        end
      end
      default: begin
        phase_d = PH_STAMP;
      end
    endcase

    // Running status and any partial message never outlive their packet.
    if (last) begin
      phase_d    = PH_HEADER;
      run_d      = '0;
      held_st_d  = '0;
      held_dat_d = '0;
      need_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      run_q      <= '0;
      held_st_q  <= '0;
      held_dat_q <= '0;
      need_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      run_q      <= run_d;
      held_st_q  <= held_st_d;
      held_dat_q <= held_dat_d;
      need_q     <= need_d;
    end
  end

endmodule

// ----- src/bmd_counters.sv -----
module bmd_counters #(
  parameter int unsigned CounterBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  bmd_pkg::bmd_cnt_ev_t ev_i,
  output logic [31:0]          stamp_d_o,
  output logic [31:0]          invalid_d_o,
  output logic [31:0]          trunc_d_o,
  output logic [31:0]          rx_d_o
);
  import bmd_pkg::*;

  logic [CounterBits-1:0] stamp_q, stamp_d;
  logic [CounterBits-1:0] inv_q, inv_d;
  logic [CounterBits-1:0] trunc_q, trunc_d;
  logic [CounterBits-1:0] rx_q, rx_d;

  // A clear request zeroes the counts before this byte is counted.
  always_comb begin
    stamp_d = (ev_i.clear ? '0 : stamp_q) + CounterBits'(ev_i.stamp);
    inv_d   = (ev_i.clear ? '0 : inv_q) + CounterBits'(ev_i.invalid);
    trunc_d = (ev_i.clear ? '0 : trunc_q) + CounterBits'(ev_i.trunc);
    rx_d    = (ev_i.clear ? '0 : rx_q) + CounterBits'(1);
  end

  assign stamp_d_o   = 32'(stamp_d);
  assign invalid_d_o = 32'(inv_d);
  assign trunc_d_o   = 32'(trunc_d);
  assign rx_d_o      = 32'(rx_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      inv_q   <= '0;
      trunc_q <= '0;
      rx_q    <= '0;
    end else if (step_i) begin
      stamp_q <= stamp_d;
      inv_q   <= inv_d;
      trunc_q <= trunc_d;
      rx_q    <= rx_d;
    end
  end

endmodule

// ----- src/ble_midi_packet_decoder.sv -----
// BLE-MIDI packet decoder. Packet bytes enter one per transaction, header byte
// first, with packet_end set on the last byte; every byte yields exactly one
// result carrying 0 to 3 raw MIDI bytes and the four wrapping counters as they
// stand after that byte. A byte is registered on entry, decoded against the
// per-packet state combinationally and written to the result register, so the
// block sustains one byte per cycle while the receiver keeps out_ready high;
// the single state update per byte is the only loop. Counters are COUNTER_BITS
// wide and zero-extended to 32 bits on the result.
module ble_midi_packet_decoder #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmd_pkg::bmd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmd_pkg::bmd_out_t out_data_o
);
  import bmd_pkg::*;

  logic        in_valid_q;
  bmd_in_t     in_q;
  logic        out_valid_q;
  bmd_out_t    out_q, out_d;
  logic        step;
  bmd_msg_t    msg;
  bmd_cnt_ev_t ev;
  logic [31:0] stamp_cnt, inv_cnt, trunc_cnt, rx_cnt;

  // The decode step fires when the result register is free or being emptied.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  bmd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .msg_o  (msg),
    .ev_o   (ev)
  );

  bmd_counters #(
    .CounterBits (COUNTER_BITS)
  ) u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .ev_i        (ev),
    .stamp_d_o   (stamp_cnt),
    .invalid_d_o (inv_cnt),
    .trunc_d_o   (trunc_cnt),
    .rx_d_o      (rx_cnt)
  );

  always_comb begin
    out_d                 = '0;
    out_d.out_count       = msg.count;
    out_d.out_byte0       = msg.byte0;
    out_d.out_byte1       = msg.byte1;
    out_d.out_byte2       = msg.byte2;
    out_d.timestamp_drops = stamp_cnt;
    out_d.invalid_drops   = inv_cnt;
    out_d.truncated_drops = trunc_cnt;
    out_d.bytes_received  = rx_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/bmd_decode_monitor.sv -----
`timescale 1ns / 1ps

module bmd_decode_monitor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bmd_pkg::bmd_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bmd_pkg::bmd_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import bmd_pkg::*;

  // Decoder state as the block should hold it.
  bmd_phase_e  phase;
  logic [7:0]  run_status;
  logic [7:0]  held_status;
  logic [6:0]  held_data;
  logic [1:0]  data_left;
  logic [31:0] stamp_drops;
  logic [31:0] invalid_drops;
  logic [31:0] trunc_drops;
  logic [31:0] rx_bytes;

  bmd_out_t    midi_expected_q[$];
  int          mismatches;

  function automatic logic [1:0] midi_data_bytes(input logic [7:0] st);
    logic [7:0] hi;
    hi = st & SysNibble;
    if (hi == ProgChange || hi == ChanPress) begin
      return 2'd1;
    end
    if (hi >= StatusBit && hi <= PitchBend) begin
      return 2'd2;
    end
    if (st == SongPos) begin
      return 2'd2;
    end
    return 2'd0;
  endfunction

  task automatic decode_packet_byte(input bmd_in_t item, output bmd_out_t res);
    logic [7:0] b;
    logic [1:0] need;
    logic       last;
    b    = item.packet_byte;
    last = item.packet_end;
    res  = '0;
    if (item.clear_counts) begin
      stamp_drops   = '0;
      invalid_drops = '0;
      trunc_drops   = '0;
      rx_bytes      = '0;
    end
    rx_bytes++;

    case (phase)
      PH_STAMP: begin
        if (b[7]) begin
          phase = PH_MSG;
        end else begin
          stamp_drops++;
        end
      end
      PH_MSG: begin
        if (b >= RealtimeMin) begin
          res.out_count = 2'd1;
          res.out_byte0 = b;
          phase = PH_STAMP;
        end else if (b[7]) begin
          need = midi_data_bytes(b);
          run_status = (b < SysNibble) ? b : 8'h00;
          if (need == 2'd0) begin
            // Unsupported system status: the byte after it is swallowed.
            stamp_drops++;
            phase = PH_SKIP;
          end else if (last) begin
            trunc_drops++;
          end else begin
            held_status = b;
            held_data   = '0;
            data_left   = need;
            phase = PH_DATA;
          end
        end else if (run_status == 8'h00) begin
          phase = PH_STAMP;
        end else begin
          need = midi_data_bytes(run_status);
          if (need == 2'd1) begin
            res.out_count = 2'd2;
            res.out_byte0 = run_status;
            res.out_byte1 = b;
            phase = PH_STAMP;
          end else if (last) begin
            trunc_drops++;
          end else begin
            held_status = run_status;
            held_data   = b[6:0];
            data_left   = 2'd1;
            phase = PH_DATA;
          end
        end
      end
      PH_SKIP: begin
        phase = PH_STAMP;
      end
      PH_DATA: begin
        need = midi_data_bytes(held_status);
        if (need == 2'd2 && data_left == 2'd1) begin
          if (b[7]) begin
            // The bad byte is taken as the timestamp of the next message.
            invalid_drops++;
            phase = PH_MSG;
          end else begin
            res.out_count = 2'd3;
            res.out_byte0 = held_status;
            res.out_byte1 = {1'b0, held_data};
            res.out_byte2 = b;
            phase = PH_STAMP;
          end
        end else if (need == 2'd2 && last) begin
          trunc_drops++;
        end else if (b[7]) begin
          invalid_drops++;
          phase = PH_STAMP;
        end else if (need == 2'd2) begin
          held_data = b[6:0];
          data_left = 2'd1;
        end else begin
          res.out_count = 2'd2;
          res.out_byte0 = held_status;
          res.out_byte1 = b;
          phase = PH_STAMP;
        end
      end
      default: begin
        phase = PH_STAMP;
      end
    endcase

    if (last) begin
      phase       = PH_HEADER;
      run_status  = '0;
      held_status = '0;
      held_data   = '0;
      data_left   = '0;
    end

    res.timestamp_drops = stamp_drops;
    res.invalid_drops   = invalid_drops;
    res.truncated_drops = trunc_drops;
    res.bytes_received  = rx_bytes;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bmd_out_t exp_res;
    bmd_out_t got;
    if (!rst_ni) begin
      phase         = PH_HEADER;
      run_status    = '0;
      held_status   = '0;
      held_data     = '0;
      data_left     = '0;
      stamp_drops   = '0;
      invalid_drops = '0;
      trunc_drops   = '0;
      rx_bytes      = '0;
      midi_expected_q.delete();
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_packet_byte(in_data_i, exp_res);
        midi_expected_q.push_back(exp_res);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (midi_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected decode transaction n=%0d bytes=%h %h %h", $realtime,
                     got.out_count, got.out_byte0, got.out_byte1, got.out_byte2);
          end
        end else begin
          exp_res = midi_expected_q.pop_front();
          if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: decode mismatch", $realtime);
              $display("  expected n=%0d bytes=%h %h %h ts=%0d inv=%0d trunc=%0d rx=%0d",
                       exp_res.out_count, exp_res.out_byte0, exp_res.out_byte1,
                       exp_res.out_byte2, exp_res.timestamp_drops, exp_res.invalid_drops,
                       exp_res.truncated_drops, exp_res.bytes_received);
              $display("  actual   n=%0d bytes=%h %h %h ts=%0d inv=%0d trunc=%0d rx=%0d",
                       got.out_count, got.out_byte0, got.out_byte1, got.out_byte2,
                       got.timestamp_drops, got.invalid_drops, got.truncated_drops,
                       got.bytes_received);
            end
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= midi_expected_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import bmd_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bmd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bmd_out_t out_data;

  int       fails;
  int       pending;
  int       sent = 0;
  bit       steady = 1'b0;
  bit       drained_mid = 1'b0;
  bmd_in_t  pkt_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ble_midi_packet_decoder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  bmd_decode_monitor u_decode_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // Counter clears are sprinkled in at random on every staged byte.
  function automatic void stage(input logic [7:0] b, input logic last = 1'b0);
    pkt_q.push_back(bmd_in_t'{packet_byte: b, packet_end: last,
                              clear_counts: ($urandom_range(0, 63) == 0)});
  endfunction

  function automatic logic [7:0] data_byte();
    if ($urandom_range(0, 15) == 0) begin
      return 8'(StatusBit | $urandom_range(0, 127));
    end
    return 8'($urandom_range(0, 127));
  endfunction

  // Mostly well-formed packets: header, then timestamped messages with random
  // content. Some are pure noise, some are cut short.
  function automatic void build_random_packet();
    int         kind;
    int         rs_len;
    int         cut;
    logic [7:0] st;
    pkt_q.delete();
    rs_len = 0;
    stage(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 7)) stage(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        stage(8'(StatusBit | $urandom_range(0, 127)));
        kind = $urandom_range(0, 15);
        if (kind <= 6) begin
          st = 8'(($urandom_range(8, 14) << 4) | $urandom_range(0, 15));
          rs_len = ((st & SysNibble) == ProgChange || (st & SysNibble) == ChanPress) ? 1 : 2;
          stage(st);
          repeat (rs_len) stage(data_byte());
        end else if (kind <= 9) begin
          repeat ((rs_len == 0) ? 1 : rs_len) stage(data_byte());
        end else if (kind == 10) begin
          stage(8'($urandom_range(RealtimeMin, 255)));
        end else if (kind == 11) begin
          stage(SongPos);
          stage(data_byte());
          stage(data_byte());
          rs_len = 0;
        end else if (kind == 12) begin
          do begin
            st = 8'(SysNibble | $urandom_range(0, 7));
          end while (st == SongPos);
          stage(st);
          stage(8'($urandom_range(0, 255)));
          rs_len = 0;
        end else if (kind == 13) begin
          // Replace the timestamp with a plain data byte.
          pkt_q[$].packet_byte = 8'($urandom_range(0, 127));
        end else begin
          stage(8'($urandom_range(0, 255)));
        end
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, pkt_q.size());
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
    pkt_q[$].packet_end = 1'b1;
  endfunction

  task automatic send_packet();
    int gap;
    foreach (pkt_q[i]) begin
      gap = draw_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= pkt_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent++;
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls before each transaction.
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pkt_q.delete();
    // One-byte packet that also clears the counters.
    stage(8'h3A, 1'b1);
    pkt_q[0].clear_counts = 1'b1;
    // Song position, program change with running status, a bad second data
    // byte rescanned as a timestamp, a system status that swallows the next
    // byte, a missing timestamp, and a timestamp as the last byte.
    stage(8'hFF);
    stage(8'h80);
    stage(SongPos);
    stage(8'h00);
    stage(8'h7F);
    stage(8'hBF);
    stage(8'hC5);
    stage(8'h10);
    stage(8'h81);
    stage(8'h11);
    stage(8'h82);
    stage(8'h8F);
    stage(8'h01);
    stage(8'hF2);
    stage(8'hF1);
    stage(8'h55);
    stage(8'h12);
    stage(8'h83, 1'b1);
    // Data without running status, a bad first data byte, and a packet that
    // ends inside a message on a byte with bit 7 set.
    stage(8'h00);
    stage(8'h80);
    stage(8'h23);
    stage(8'h80);
    stage(8'hA0);
    stage(8'h90);
    stage(8'h80);
    stage(8'hB0);
    stage(8'h85, 1'b1);
    send_packet();
    wait_for_results();

    while (sent < 750) begin
      if ($urandom_range(0, 9) == 0) begin
        steady = !steady;
      end
      build_random_packet();
      send_packet();
      if (!drained_mid && sent >= 375) begin
        wait_for_results();
        drained_mid = 1'b1;
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
